/* rtl/core/sat_pkg.sv */
// shared constants and types for the shifting array table
package sat_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned HDL_W   = 32;
  localparam int unsigned ENTRY_W = KEY_W + HDL_W;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_UPDATE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_e;

endpackage

/* rtl/core/sat_ram.sv */
// generic single write, single read ram with registered read data
module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/shifting_array_table_top.sv */
// ordered key and handle table with insert, delete, search, read and update
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+----------------------
//  command   | start, busy, mode_i, index_i, key_i,      | start high, busy low
//            | handle_i                                  |
//  result    | done_o, status_o, found_index_o,          | done_o high, one cycle
//            | key_out_o, handle_out_o, entry_count_o    |
//
//  one entry is moved or compared per cycle through the single ram port pair;
//  insert shifts the tail up from the end, delete shifts it down, search
//  compares every entry, read fetches one, update and rejected commands none
//  reset clears the entry count and control state; the entry ram holds no reset
//  busy stays high from acceptance until the result strobe cycle
//  the receiver cannot stall, so each result shows for exactly one cycle
module shifting_array_table_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             mode_i,
  input  logic [sat_pkg::IDX_W-1:0] index_i,
  input  logic [sat_pkg::KEY_W-1:0] key_i,
  input  logic [sat_pkg::HDL_W-1:0] handle_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [sat_pkg::IDX_W-1:0] found_index_o,
  output logic [sat_pkg::KEY_W-1:0] key_out_o,
  output logic [sat_pkg::HDL_W-1:0] handle_out_o,
  output logic [sat_pkg::CNT_W-1:0] entry_count_o
);
  import sat_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [2:0]         mode_q;
  logic [IDX_W-1:0]   idx_q;
  logic [KEY_W-1:0]   key_q;
  logic [HDL_W-1:0]   hdl_q;
  status_e            st_q, st_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic               up_q, up_d;
  logic               mv_q, mv_d;
  logic               cmp_q, cmp_d;
  logic [IDX_W-1:0]   dst_q, dst_d;
  logic [IDX_W-1:0]   cidx_q, cidx_d;
  logic               hit_q, hit_d;
  logic [IDX_W-1:0]   pos_q;
  logic [KEY_W-1:0]   fkey_q;
  logic [HDL_W-1:0]   fhdl_q;

  logic               done_q;
  logic [1:0]         status_q;
  logic [IDX_W-1:0]   fidx_q;
  logic [KEY_W-1:0]   kout_q;
  logic [HDL_W-1:0]   hout_q;

  logic               accept;
  logic [CNT_W-1:0]   idx_ext;
  logic               idx_lt;
  logic               capture;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_wa;
  logic [ENTRY_W-1:0] ram_wd;
  logic [ENTRY_W-1:0] ram_rd;
  logic               is_find;

  assign accept  = start && (state_q == S_IDLE);
  assign idx_ext = CNT_W'(index_i);
  assign idx_lt  = idx_ext < cnt_q;
  assign capture = cmp_q && ((mode_q == MODE_READ) || (ram_rd[ENTRY_W-1:HDL_W] == key_q));
  assign is_find = (mode_q == MODE_READ) || (mode_q == MODE_SEARCH);

  // command decode and walk sequencer
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    ptr_d   = ptr_q;
    rem_d   = rem_q;
    up_d    = up_q;
    mv_d    = 1'b0;
    cmp_d   = 1'b0;
    dst_d   = dst_q;
    cidx_d  = cidx_q;
    hit_d   = hit_q || capture;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          hit_d   = 1'b0;
          st_d    = ST_RANGE;
          state_d = S_FIN;
          case (mode_i)
            MODE_READ: begin
              if (idx_lt) begin
                st_d    = ST_OK;
                ptr_d   = index_i;
                rem_d   = CNT_W'(1);
                up_d    = 1'b1;
                state_d = S_WALK;
              end
            end
            MODE_INSERT: begin
              if (cnt_q >= CNT_W'(DEPTH)) begin
                st_d = ST_FULL;
              end else if (idx_ext <= cnt_q) begin
                st_d    = ST_OK;
                ptr_d   = IDX_W'(cnt_q - CNT_W'(1));
                rem_d   = cnt_q - idx_ext;
                up_d    = 1'b0;
                state_d = S_WALK;
              end
            end
            MODE_DELETE: begin
              if (idx_lt) begin
                st_d    = ST_OK;
                ptr_d   = index_i + IDX_W'(1);
                rem_d   = cnt_q - idx_ext - CNT_W'(1);
                up_d    = 1'b1;
                state_d = S_WALK;
              end
            end
            MODE_SEARCH: begin
              st_d    = ST_OK;
              ptr_d   = '0;
              rem_d   = cnt_q;
              up_d    = 1'b1;
              state_d = S_WALK;
            end
            MODE_UPDATE: begin
              if (idx_lt) begin
                st_d = ST_OK;
              end
            end
            default: begin
              st_d = ST_RANGE;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rem_q != '0) begin
          rem_d  = rem_q - CNT_W'(1);
          ptr_d  = up_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
          cidx_d = ptr_q;
          if ((mode_q == MODE_INSERT) || (mode_q == MODE_DELETE)) begin
            mv_d  = 1'b1;
            dst_d = up_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
          end else begin
            cmp_d = 1'b1;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
        if (st_q == ST_OK) begin
          if (mode_q == MODE_INSERT) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else if (mode_q == MODE_DELETE) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ram write port: pending move first, then the new entry
  always_comb begin
    ram_we = 1'b0;
    ram_wa = dst_q;
    ram_wd = ram_rd;
    if (mv_q) begin
      ram_we = 1'b1;
    end else if ((state_q == S_FIN) && (st_q == ST_OK) &&
                 ((mode_q == MODE_INSERT) || (mode_q == MODE_UPDATE))) begin
      ram_we = 1'b1;
      ram_wa = idx_q;
      ram_wd = {key_q, hdl_q};
    end
  end

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ptr_q),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
      cmp_q   <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      cmp_q   <= cmp_d;
      done_q  <= (state_q == S_FIN);
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      idx_q  <= index_i;
      key_q  <= key_i;
      hdl_q  <= handle_i;
    end
    st_q   <= st_d;
    ptr_q  <= ptr_d;
    rem_q  <= rem_d;
    up_q   <= up_d;
    dst_q  <= dst_d;
    cidx_q <= cidx_d;
    if (capture) begin
      pos_q  <= cidx_q;
      fkey_q <= ram_rd[ENTRY_W-1:HDL_W];
      fhdl_q <= ram_rd[HDL_W-1:0];
    end
    if (state_q == S_FIN) begin
      if (mode_q == MODE_SEARCH) begin
        status_q <= hit_q ? ST_OK : ST_MISS;
        fidx_q   <= hit_q ? pos_q : '0;
      end else begin
        status_q <= st_q;
        fidx_q   <= idx_q;
      end
      kout_q <= (is_find && hit_q) ? fkey_q : '0;
      hout_q <= (is_find && hit_q) ? fhdl_q : '0;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = fidx_q;
  assign key_out_o     = kout_q;
  assign handle_out_o  = hout_q;
  assign entry_count_o = cnt_q;

endmodule

/* rtl/core/sat_checker.sv */
// port level checks for the shifting array table, bound to the top level
module sat_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input logic                   done_o,
  input logic [1:0]             status_o,
  input logic [sat_pkg::IDX_W-1:0] found_index_o,
  input logic [sat_pkg::KEY_W-1:0] key_out_o,
  input logic [sat_pkg::HDL_W-1:0] handle_out_o,
  input logic [sat_pkg::CNT_W-1:0] entry_count_o
);
  import sat_pkg::*;

  // a transfer makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // result strobe comes exactly when busy drops
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without result");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_count_o <= CNT_W'(DEPTH)))
    else $error("entry count beyond table depth");

  // a miss reports position zero and no data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_MISS)) |->
      ((found_index_o == '0) && (key_out_o == '0) && (handle_out_o == '0)))
    else $error("search miss with non-zero result");

endmodule

bind shifting_array_table_top sat_checker u_sat_checker (.*);
